// File: design/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants of the fixed step accumulator: field widths,
// request and response structs, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package fsa_pkg;

   // field widths
   localparam int DELTA_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int PERIOD_W      = 32;
   localparam int CATCH_W       = 8;
   localparam int TIME_W        = 64;

   // derived widths
   localparam int CLAMP_W  = PERIOD_W + CATCH_W;
   localparam int SUM_W    = DELTA_BITS + 1;
   localparam int QUOT_W   = (SUM_W > FRACTION_BITS) ? SUM_W : FRACTION_BITS;
   localparam int CNT_W    = $clog2(QUOT_W + 1);
   localparam int CMP_W    = (DELTA_BITS > CLAMP_W) ? DELTA_BITS : CLAMP_W;

   // defaults taken when a register holds zero
   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(16667);
   localparam logic [CATCH_W-1:0]  DEFAULT_CATCH  = CATCH_W'(1);

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CATCH_UP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_DELTA = 2'd2;

   // request kinds
   localparam logic KIND_ADVANCE = 1'b0;
   localparam logic KIND_RESET   = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [DELTA_BITS-1:0] frame_delta;
      logic [TIME_W-1:0]     start_time;
   } fsa_req_type;

   typedef struct packed {
      logic [CATCH_W-1:0]       step_count;
      logic [FRACTION_BITS-1:0] blend_fraction;
      logic [DELTA_BITS-1:0]    clamped_delta;
      logic                     delta_was_clamped;
      logic [TIME_W-1:0]        sim_time;
      logic [DELTA_BITS-1:0]    leftover;
   } fsa_rsp_type;

   // command to the serial divider
   typedef struct packed {
      logic                start;
      logic [PERIOD_W-1:0] init_rem;
      logic [QUOT_W-1:0]   dividend;
      logic [CNT_W-1:0]    bit_count;
   } fsa_div_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_SUM,
      ST_QUOT,
      ST_SCALE,
      ST_FRAC,
      ST_DONE
   } fsa_state_type;

endpackage

`default_nettype wire

// File: design/fsa_div.sv
// ----------------------------------------------------------------------------
// fsa_div
// Bit-serial restoring divider, one quotient bit per cycle. The partial
// remainder may be preloaded, which gives a fraction division for free.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire fsa_pkg::fsa_div_cmd_type        cmd,
   input  wire logic [fsa_pkg::PERIOD_W-1:0]    divisor,
   output logic      [fsa_pkg::QUOT_W-1:0]      quotient,
   output logic      [fsa_pkg::PERIOD_W-1:0]    remainder,
   output logic                                 done
);
   import fsa_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;

   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W+1:0] diff;
   logic                fits;

   // shift the next dividend bit into the partial remainder, try a subtract
   assign trial = {rem_ff, quot_ff[QUOT_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, divisor};
   assign fits  = ~diff[PERIOD_W+1];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = cmd.bit_count;
         quot_in  = cmd.dividend;
         rem_in   = cmd.init_rem;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[QUOT_W-2:0], fits};
         rem_in   = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

// File: design/fixed_step_accumulator.sv
// ----------------------------------------------------------------------------
// fixed_step_accumulator
// Turns variable frame deltas into whole fixed simulation steps, keeps the
// simulation time and the leftover time, and gives a blend fraction.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_ready   fsa_req_type (advance or reset)
//   rsp_      out         rsp_valid/rsp_ready   fsa_rsp_type (one per request)
//   csr_      in          csr_we                csr_index, csr_wdata
//
// an advance request passes through the clamp, sum, quotient, scale, fraction
// and done states from accept to response; the bit-serial divider runs once
// over the sum and once over the fraction
// a reset request passes through only the clamp and done states
// one request is worked at a time; a new request is taken while the previous
// response still waits in the output register
// reset is synchronous; it restores the register defaults and clears time
//
`default_nettype none

module fixed_step_accumulator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire fsa_pkg::fsa_req_type               req_data,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output fsa_pkg::fsa_rsp_type                    rsp_data,
   // configuration writes
   input  wire logic                               csr_we,
   input  wire logic [fsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [fsa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fsa_pkg::*;

   // configuration registers
   logic [PERIOD_W-1:0] period_ff;
   logic [CATCH_W-1:0]  catch_ff;
   logic [PERIOD_W-1:0] max_delta_ff;

   // zero in a register selects its default
   logic [PERIOD_W-1:0] eff_period;
   logic [CATCH_W-1:0]  eff_catch;

   // controller
   fsa_state_type state_ff, state_in;

   // accumulator state
   logic [DELTA_BITS-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0]     sim_ff, sim_in;

   // working registers of the request in flight
   fsa_req_type           req_ff, req_in;
   logic [CLAMP_W-1:0]    clamp_ff, clamp_in;
   logic [DELTA_BITS-1:0] clamped_ff, clamped_in;
   logic                  flag_ff, flag_in;
   logic [CATCH_W-1:0]    steps_ff, steps_in;
   logic [DELTA_BITS-1:0] left_ff, left_in;
   logic [CLAMP_W-1:0]    prod_ff, prod_in;
   fsa_rsp_type           res_ff, res_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   fsa_rsp_type           rsp_ff, rsp_in;

   // divider
   fsa_div_cmd_type       div_cmd;
   logic [QUOT_W-1:0]     div_quot;
   logic [PERIOD_W-1:0]   div_rem;
   logic                  div_done;

   // datapath helpers
   logic                  over_clamp;
   logic [DELTA_BITS-1:0] clamped_val;
   logic [SUM_W-1:0]      sum_val;
   logic                  at_limit;
   logic [FRACTION_BITS-1:0] frac_val;

   assign eff_period = (period_ff != '0) ? period_ff : DEFAULT_PERIOD;
   assign eff_catch  = (catch_ff != '0) ? catch_ff : DEFAULT_CATCH;

   // register writes; the user must write only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= DEFAULT_PERIOD;
         catch_ff     <= DEFAULT_CATCH;
         max_delta_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_PERIOD:     period_ff    <= PERIOD_W'(csr_wdata);
            CSR_MAX_CATCH_UP:    catch_ff     <= CATCH_W'(csr_wdata);
            CSR_MAX_FRAME_DELTA: max_delta_ff <= PERIOD_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   fsa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .divisor   (eff_period),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   // clamp compare and sum of the stored remainder with the clamped delta
   assign over_clamp  = CMP_W'(req_ff.frame_delta) > CMP_W'(clamp_ff);
   assign clamped_val = over_clamp ? DELTA_BITS'(clamp_ff) : req_ff.frame_delta;
   assign sum_val     = SUM_W'(rem_ff) + SUM_W'(clamped_val);

   // whole steps reach the catch-up limit
   assign at_limit = (div_quot[QUOT_W-1:CATCH_W] != '0)
                  || (div_quot[CATCH_W-1:0] >= eff_catch);

   // fraction saturates at all ones, which a remainder below the period never hits
   assign frac_val = ((div_quot >> FRACTION_BITS) != '0) ? '1
                   : div_quot[FRACTION_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      sim_in       = sim_ff;
      req_in       = req_ff;
      clamp_in     = clamp_ff;
      clamped_in   = clamped_ff;
      flag_in      = flag_ff;
      steps_in     = steps_ff;
      left_in      = left_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      div_cmd      = '0;

      // response taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (req_ff.kind == KIND_RESET) begin
               // load the start time and drop the remainder
               sim_in   = req_ff.start_time;
               rem_in   = '0;
               res_in   = '0;
               res_in.sim_time = req_ff.start_time;
               state_in = ST_DONE;
            end else begin
               // clamp is the register, or period times catch-up when it is zero
               clamp_in = (max_delta_ff != '0) ? CLAMP_W'(max_delta_ff)
                        : CLAMP_W'(eff_period) * CLAMP_W'(eff_catch);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            clamped_in        = clamped_val;
            flag_in           = over_clamp;
            div_cmd.start     = 1'b1;
            div_cmd.init_rem  = '0;
            div_cmd.dividend  = QUOT_W'(sum_val);
            div_cmd.bit_count = CNT_W'(SUM_W);
            state_in          = ST_QUOT;
         end
         ST_QUOT: begin
            if (div_done) begin
               steps_in = at_limit ? eff_catch : div_quot[CATCH_W-1:0];
               left_in  = DELTA_BITS'(div_rem);
               // leftover shifted up by the fraction width over the period
               div_cmd.start     = 1'b1;
               div_cmd.init_rem  = PERIOD_W'(DELTA_BITS'(div_rem));
               div_cmd.dividend  = '0;
               div_cmd.bit_count = CNT_W'(FRACTION_BITS);
               state_in          = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = CLAMP_W'(steps_ff) * CLAMP_W'(eff_period);
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            if (div_done) begin
               sim_in = sim_ff + TIME_W'(prod_ff);
               rem_in = left_ff;
               res_in.step_count        = steps_ff;
               res_in.blend_fraction    = frac_val;
               res_in.clamped_delta     = clamped_ff;
               res_in.delta_was_clamped = flag_ff;
               res_in.sim_time          = sim_ff + TIME_W'(prod_ff);
               res_in.leftover          = left_ff;
               state_in                 = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
         sim_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
         sim_ff       <= sim_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      clamp_ff   <= clamp_in;
      clamped_ff <= clamped_in;
      flag_ff    <= flag_in;
      steps_ff   <= steps_in;
      left_ff    <= left_in;
      prod_ff    <= prod_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: design/fsa_checker.sv
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks of the fixed step accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire fsa_pkg::fsa_rsp_type rsp_data
);
   import fsa_pkg::*;

   // requests accepted and not yet answered
   logic [1:0] open_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 2'(req_fire) - 2'(rsp_fire);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an open request");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> open_ff <= 2'd1)
      else $error("request taken with one already in work");

   a_zero_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.leftover == '0 |-> rsp_data.blend_fraction == '0)
      else $error("blend fraction without leftover time");

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.delta_was_clamped |-> rsp_data.clamped_delta != '0)
      else $error("clamped delta of zero");

endmodule

bind fixed_step_accumulator fsa_checker u_fsa_checker (.*);

`default_nettype wire

// File: tb/tb_fixed_step_accumulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_step_accumulator
// Self-checking bench for the fixed step accumulator. A clocked driver feeds
// advance and reset requests from a queue, and a clocked monitor predicts
// each response from a private copy of the timeline and the registers, then
// compares it field by field. Register settings change between phases, with
// sender gaps, receiver stalls and one long response hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_step_accumulator;
   import fsa_pkg::*;

   // bench limits
   localparam int WATCHDOG_CYCLES = 2000;   // cycles with no handshake at all
   localparam int LONG_HOLD       = 400;    // receiver hold-off in the pressure phase
   localparam int DRAIN_CYCLES    = 60;     // settling time after the last response
   localparam int SENDER_IDLE_PCT = 46;
   localparam int RECV_STALL_PCT  = 46;
   localparam int BOTH_IDLE_PCT   = 22;
   localparam int PHASE_ITEMS     = 90;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block ports, inputs known from time zero
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   fsa_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   fsa_rsp_type            rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   fixed_step_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // request queue for the driver, expected responses for the monitor
   fsa_req_type   pending_requests[$];
   fsa_rsp_type   expected_responses[$];
   idle_mode_type idle_mode   = IDLE_NONE;
   logic          hold_wanted = 1'b0;
   logic          req_taken   = 1'b0;

   // predicted timeline and register copies (reset values)
   logic [PERIOD_W-1:0]   cfg_step_period = DEFAULT_PERIOD;
   logic [CATCH_W-1:0]    cfg_catch_up    = DEFAULT_CATCH;
   logic [DELTA_BITS-1:0] cfg_frame_clamp = '0;
   logic [DELTA_BITS-1:0] leftover_us     = '0;
   logic [TIME_W-1:0]     sim_us          = '0;

   // run statistics
   int requests_sent   = 0;
   int requests_taken  = 0;
   int responses_seen  = 0;
   int advance_count   = 0;
   int reset_count     = 0;
   int clamp_count     = 0;
   int capped_count    = 0;
   int wrap_count      = 0;
   int phase_count     = 0;
   int error_count     = 0;
   int quiet_cycles    = 0;

   // effective step length, catch-up limit and delta clamp, zero registers
   // falling back to their defaults
   function automatic longint unsigned step_len();
      return (cfg_step_period != '0) ? longint'(cfg_step_period) : longint'(DEFAULT_PERIOD);
   endfunction

   function automatic longint unsigned catch_limit();
      return (cfg_catch_up != '0) ? longint'(cfg_catch_up) : longint'(DEFAULT_CATCH);
   endfunction

   function automatic longint unsigned delta_clamp();
      return (cfg_frame_clamp != '0) ? longint'(cfg_frame_clamp)
                                     : step_len() * catch_limit();
   endfunction

   // predicted response for one accepted request; moves the timeline on
   function automatic fsa_rsp_type advance_timeline(input fsa_req_type r);
      fsa_rsp_type       o;
      longint unsigned   period;
      longint unsigned   limit;
      longint unsigned   clamp;
      longint unsigned   sum;
      longint unsigned   whole;
      longint unsigned   steps;
      longint unsigned   frac;
      logic [TIME_W-1:0] old_time;
      o = '0;
      if (r.kind == KIND_RESET) begin
         // reset request: load the start time, drop the leftover
         sim_us      = r.start_time;
         leftover_us = '0;
         o.sim_time  = sim_us;
         reset_count++;
         return o;
      end
      period = step_len();
      limit  = catch_limit();
      clamp  = delta_clamp();
      // flag only when strictly above the clamp
      o.delta_was_clamped = longint'(r.frame_delta) > clamp;
      o.clamped_delta     = o.delta_was_clamped ? clamp[DELTA_BITS-1:0] : r.frame_delta;
      sum   = longint'(leftover_us) + longint'(o.clamped_delta);
      whole = sum / period;
      steps = (whole < limit) ? whole : limit;
      // excess time beyond the catch-up limit is dropped
      leftover_us = DELTA_BITS'(sum % period);
      old_time    = sim_us;
      sim_us      = sim_us + steps * period;
      frac = (longint'(leftover_us) << FRACTION_BITS) / period;
      if (frac > {FRACTION_BITS{1'b1}})
         frac = {FRACTION_BITS{1'b1}};
      o.step_count     = steps[CATCH_W-1:0];
      o.blend_fraction = frac[FRACTION_BITS-1:0];
      o.sim_time       = sim_us;
      o.leftover       = leftover_us;
      advance_count++;
      if (o.delta_was_clamped)
         clamp_count++;
      if (whole > limit)
         capped_count++;
      if (sim_us < old_time)
         wrap_count++;
      return o;
   endfunction

   // random request shaped around the current step length and clamp
   function automatic fsa_req_type random_request();
      fsa_req_type     r;
      longint unsigned period;
      longint unsigned limit;
      longint unsigned span;
      period         = step_len();
      limit          = catch_limit();
      r.kind         = ($urandom_range(0, 99) < 12) ? KIND_RESET : KIND_ADVANCE;
      r.start_time   = {$urandom, $urandom};
      r.frame_delta  = $urandom;
      if (r.kind == KIND_RESET) begin
         case ($urandom_range(0, 3))
            0: r.start_time = '1 - TIME_W'($urandom_range(0, 200000));
            1: r.start_time = TIME_W'($urandom_range(0, 100000));
            default: ;
         endcase
      end else begin
         case ($urandom_range(0, 7))
            0: r.frame_delta = '0;
            1: ;   // full-range delta
            2, 3: begin
               span = period * 3;
               if (span > 64'hFFFF_FFFF)
                  span = 64'hFFFF_FFFF;
               r.frame_delta = $urandom_range(0, span[31:0]);
            end
            4: begin
               // whole multiple of the step length
               span = period * longint'($urandom_range(1, 300));
               r.frame_delta = span[DELTA_BITS-1:0];
            end
            5: begin
               // right around the clamp
               span = delta_clamp() - 1 + longint'($urandom_range(0, 2));
               r.frame_delta = span[DELTA_BITS-1:0];
            end
            6: r.frame_delta = '1 - DELTA_BITS'($urandom_range(0, 3));
            default: begin
               span = 2 * period * limit;
               if (span > 64'hFFFF_FFFF)
                  span = 64'hFFFF_FFFF;
               r.frame_delta = $urandom_range(0, span[31:0]);
            end
         endcase
      end
      return r;
   endfunction

   task automatic push_request(input logic kind, input logic [DELTA_BITS-1:0] delta,
                               input logic [TIME_W-1:0] start);
      fsa_req_type r;
      r.kind        = kind;
      r.frame_delta = delta;
      r.start_time  = start;
      pending_requests.push_back(r);
      requests_sent++;
   endtask

   task automatic push_random(input int count);
      repeat (count) begin
         pending_requests.push_back(random_request());
         requests_sent++;
      end
   endtask

   // all requests taken and every response back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (requests_taken != requests_sent || expected_responses.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_STEP_PERIOD:     cfg_step_period = value[PERIOD_W-1:0];
         CSR_MAX_CATCH_UP:    cfg_catch_up    = value[CATCH_W-1:0];
         CSR_MAX_FRAME_DELTA: cfg_frame_clamp = value[DELTA_BITS-1:0];
         default: ;
      endcase
   endtask

   // new register setting once the block has gone quiet
   task automatic begin_phase(input logic [CSR_DATA_W-1:0] period,
                              input logic [CSR_DATA_W-1:0] catch_up,
                              input logic [CSR_DATA_W-1:0] frame_clamp,
                              input idle_mode_type mode);
      wait_drained();
      repeat (4) @(negedge clock);
      write_register(CSR_STEP_PERIOD, period);
      write_register(CSR_MAX_CATCH_UP, catch_up);
      write_register(CSR_MAX_FRAME_DELTA, frame_clamp);
      // queue fills happen just after a rising edge, clear of the driver
      @(posedge clock);
      idle_mode <= mode;
      phase_count++;
   endtask

   task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                                input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // request driver: holds an offered request until it is taken
   always @(negedge clock) begin : request_driver
      bit pause;
      pause = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < SENDER_IDLE_PCT) ||
              (idle_mode == IDLE_BOTH   && $urandom_range(0, 99) < BOTH_IDLE_PCT);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && !pause) begin
            req_valid <= 1'b1;
            req_data  <= pending_requests.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure, with one long hold-off counted here
   always @(negedge clock) begin : response_throttle
      int hold_left;
      bit hold_done;
      bit stall;
      stall = (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < RECV_STALL_PCT) ||
              (idle_mode == IDLE_BOTH     && $urandom_range(0, 99) < BOTH_IDLE_PCT);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !stall;
      end
   end

   // monitor: predicts on request handshakes, checks on response handshakes
   always @(posedge clock) begin : handshake_monitor
      fsa_rsp_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_valid && req_ready;
         // check first so a response can never match the request taken with it
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding: sim_time 0x%0h",
                      rsp_data.sim_time);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               compare_field("step_count", want.step_count, rsp_data.step_count);
               compare_field("blend_fraction", want.blend_fraction, rsp_data.blend_fraction);
               compare_field("clamped_delta", want.clamped_delta, rsp_data.clamped_delta);
               compare_field("delta_was_clamped", want.delta_was_clamped,
                             rsp_data.delta_was_clamped);
               compare_field("sim_time", want.sim_time, rsp_data.sim_time);
               compare_field("leftover", want.leftover, rsp_data.leftover);
            end
         end
         if (req_valid && req_ready) begin
            expected_responses.push_back(advance_timeline(req_data));
            requests_taken++;
         end
         // watchdog on handshake activity
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, expected_responses.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, register reset values: period 16667, one step, clamp 16667
      push_request(KIND_ADVANCE, '0, '0);
      push_request(KIND_ADVANCE, 32'd1, '1);                 // start time ignored
      push_request(KIND_ADVANCE, 32'd16665, '0);             // just short of a step
      push_request(KIND_ADVANCE, 32'd1, '0);                 // exactly one step
      push_request(KIND_ADVANCE, 32'd16667, '0);             // equal to clamp, no flag
      push_request(KIND_ADVANCE, 32'd16668, '0);             // one above clamp
      push_request(KIND_ADVANCE, '1, '0);                    // widest delta
      push_request(KIND_RESET, '1, 64'hFFFF_FFFF_FFFF_C000); // delta ignored
      push_request(KIND_ADVANCE, 32'd16667, '0);             // time wraps
      push_request(KIND_ADVANCE, 32'd16667, '0);
      push_request(KIND_RESET, '0, '0);
      push_request(KIND_RESET, '0, '1);
      push_request(KIND_ADVANCE, 32'd16667, '0);             // wraps from all ones
      push_request(KIND_RESET, '0, 64'h5555_5555_5555_5555);
      push_request(KIND_ADVANCE, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
      push_request(KIND_ADVANCE, 32'd8333, '0);              // half a step

      // directed catch-up limit: excess time beyond three steps is dropped
      begin_phase(32'd1000, 32'd3, 32'hFFFF_FFFF, IDLE_NONE);
      push_request(KIND_ADVANCE, 32'd5500, '0);
      push_request(KIND_ADVANCE, 32'd2499, '0);
      push_request(KIND_ADVANCE, 32'd2001, '0);
      push_request(KIND_ADVANCE, 32'd3999, '0);
      push_request(KIND_ADVANCE, 32'd1, '0);
      push_request(KIND_RESET, '0, 64'h8000_0000_0000_0000);

      // random phases; zero registers select the defaults
      begin_phase('0, '0, '0, IDLE_NONE);
      push_random(PHASE_ITEMS);
      begin_phase(32'd1, 32'd255, '0, IDLE_SENDER);
      push_random(PHASE_ITEMS);
      begin_phase(32'hFFFF_FFFF, 32'd255, '0, IDLE_RECEIVER);
      push_random(PHASE_ITEMS);
      begin_phase($urandom_range(1, 5000), $urandom_range(2, 255),
                  $urandom_range(1, 200000), IDLE_BOTH);
      push_random(PHASE_ITEMS);

      // pressure: receiver holds off while requests keep coming
      begin_phase(32'd16667, 32'd4, 32'hFFFF_FFFF, IDLE_NONE);
      hold_wanted <= 1'b1;
      push_random(PHASE_ITEMS);

      begin_phase(32'h8000_0000, 32'd2, 32'd1, IDLE_SENDER);
      push_random(PHASE_ITEMS);
      // full-width catch-up write checks the register masking
      begin_phase($urandom, $urandom, $urandom, IDLE_BOTH);
      push_random(PHASE_ITEMS);
      begin_phase(32'd7, '0, '0, IDLE_RECEIVER);
      push_random(PHASE_ITEMS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests (%0d advances, %0d resets) over %0d register settings",
               requests_taken, advance_count, reset_count, phase_count + 1);
      $display("%0d clamped deltas, %0d capped catch-ups, %0d time wraps, %0d errors",
               clamp_count, capped_count, wrap_count, error_count);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
design/fsa_pkg.sv
design/fsa_div.sv
design/fixed_step_accumulator.sv
design/fsa_checker.sv
tb/tb_fixed_step_accumulator.sv
